// ----- hdl/hhve_pkg.sv -----
// ----------------------------------------------------------------------------
// hhve_pkg
// Shared types and constants for the HTTP header value extractor: parse
// phases, result codes, configuration register indexes and the structs that
// pass between the parser, the result queue and the top level.
// ----------------------------------------------------------------------------
package hhve_pkg;

  // Characters the parser reacts to.
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Result kinds.
  localparam logic [1:0] RK_BYTE      = 2'd0;
  localparam logic [1:0] RK_FOUND     = 2'd1;
  localparam logic [1:0] RK_NOT_FOUND = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [1:0] CFG_KEY_HIGH = 2'd1;
  localparam logic [1:0] CFG_KEY_LEN  = 2'd2;

  localparam logic [15:0] VCOUNT_MAX = 16'hFFFF;

  // Result queue geometry.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  typedef enum logic [2:0] {
    PH_MATCH  = 3'd0,
    PH_SKIP   = 3'd1,
    PH_SPACES = 3'd2,
    PH_VALUE  = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  vbyte;
    logic [15:0] vlen;
  } result_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  index;
    logic [63:0] data;
  } cfg_wr_t;

  // Up to two results per header byte; slot 0 is always filled first.
  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } push_t;

  typedef struct packed {
    logic [Q_CNT_W-1:0] count;
    logic               room2;
  } q_status_t;

endpackage

// ----- hdl/hhve_parser.sv -----
// ----------------------------------------------------------------------------
// hhve_parser
// Key registers and the per-byte parse logic. One header byte is consumed
// per enabled cycle and up to two results are handed to the result queue.
// ----------------------------------------------------------------------------
module hhve_parser
  import hhve_pkg::*;
#(
  parameter int KEY_MAX_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_wr_t    cfg_wr,
  input  logic       step,
  input  logic [7:0] hdr_byte,
  input  logic       hdr_last,
  output push_t      push
);

  logic [7:0] key_r [KEY_MAX_BYTES];
  logic [4:0] key_len_r;

  phase_t      phase_r, phase_nxt;
  logic [4:0]  mcount_r, mcount_nxt;
  logic        prev_cr_r, prev_cr_nxt;
  logic [15:0] vcount_r, vcount_nxt;

  logic [4:0]  klen;
  logic [7:0]  kbyte;
  logic        crlf;
  logic        res_a_vld, res_b_vld;
  result_t     res_a, res_b;

  // Configuration registers.
  for (genvar i = 0; i < KEY_MAX_BYTES; i++) begin : g_key
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        key_r[i] <= 8'h00;
      end else if (cfg_wr.valid) begin
        if (i < 8 && cfg_wr.index == CFG_KEY_LOW) begin
          key_r[i] <= cfg_wr.data[8*(i%8) +: 8];
        end else if (i >= 8 && cfg_wr.index == CFG_KEY_HIGH) begin
          key_r[i] <= cfg_wr.data[8*(i%8) +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r <= 5'd0;
    end else if (cfg_wr.valid && cfg_wr.index == CFG_KEY_LEN) begin
      key_len_r <= cfg_wr.data[4:0];
    end
  end

  assign klen = (key_len_r > 5'(KEY_MAX_BYTES)) ? 5'(KEY_MAX_BYTES) : key_len_r;

  // Key byte at the current match position; only used while it is in range.
  always_comb begin
    kbyte = 8'h00;
    for (int i = 0; i < KEY_MAX_BYTES; i++) begin
      if (mcount_r == 5'(i)) begin
        kbyte = key_r[i];
      end
    end
  end

  assign crlf = prev_cr_r && (hdr_byte == CH_LF);

  always_comb begin
    phase_nxt   = phase_r;
    mcount_nxt  = mcount_r;
    vcount_nxt  = vcount_r;
    prev_cr_nxt = (hdr_byte == CH_CR);
    res_a_vld   = 1'b0;
    res_a       = '0;
    res_b_vld   = 1'b0;
    res_b       = '0;

    unique case (phase_r)
      PH_MATCH: begin
        if (mcount_r < klen && hdr_byte == kbyte) begin
          mcount_nxt = mcount_r + 5'd1;
        end else if (mcount_r >= klen && hdr_byte == CH_COLON) begin
          phase_nxt  = PH_SPACES;
          vcount_nxt = 16'd0;
        end else if (crlf) begin
          mcount_nxt = 5'd0;
        end else begin
          phase_nxt = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (crlf) begin
          phase_nxt  = PH_MATCH;
          mcount_nxt = 5'd0;
        end
      end
      PH_SPACES, PH_VALUE: begin
        if (!(phase_r == PH_SPACES && hdr_byte == CH_SPACE)) begin
          phase_nxt = PH_VALUE;
          res_a_vld = 1'b1;
          if (hdr_byte == CH_CR || hdr_byte == CH_NUL) begin
            res_a.kind = RK_FOUND;
            res_a.vlen = vcount_r;
            phase_nxt  = PH_DONE;
          end else begin
            res_a.kind  = RK_BYTE;
            res_a.vbyte = hdr_byte;
            if (vcount_r != VCOUNT_MAX) begin
              vcount_nxt = vcount_r + 16'd1;
            end
          end
        end
      end
      default: begin
      end
    endcase

    // End of the block: close out whatever is open and start over.
    if (hdr_last) begin
      if (phase_nxt == PH_MATCH || phase_nxt == PH_SKIP) begin
        res_b_vld  = 1'b1;
        res_b.kind = RK_NOT_FOUND;
      end else if (phase_nxt == PH_SPACES || phase_nxt == PH_VALUE) begin
        res_b_vld  = 1'b1;
        res_b.kind = RK_FOUND;
        res_b.vlen = vcount_nxt;
      end
      phase_nxt   = PH_MATCH;
      mcount_nxt  = 5'd0;
      prev_cr_nxt = 1'b0;
      vcount_nxt  = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_MATCH;
      mcount_r  <= 5'd0;
      prev_cr_r <= 1'b0;
      vcount_r  <= 16'd0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      mcount_r  <= mcount_nxt;
      prev_cr_r <= prev_cr_nxt;
      vcount_r  <= vcount_nxt;
    end
  end

  always_comb begin
    push.push0 = step && (res_a_vld || res_b_vld);
    push.push1 = step && res_a_vld && res_b_vld;
    push.res0  = res_a_vld ? res_a : res_b;
    push.res1  = res_b;
  end

endmodule

// ----- hdl/hhve_outq.sv -----
// ----------------------------------------------------------------------------
// hhve_outq
// Small result queue. Takes up to two results per cycle and delivers one per
// cycle on the result channel while pop is high.
// ----------------------------------------------------------------------------
module hhve_outq
  import hhve_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  push_t     push,
  input  logic      pop,
  output logic      empty,
  output result_t   head,
  output q_status_t status
);

  result_t            mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic [Q_CNT_W-1:0] n_push;
  logic [Q_PTR_W-1:0] wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr_r + Q_PTR_W'(1);
  assign n_push    = Q_CNT_W'(push.push0) + Q_CNT_W'(push.push1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + Q_PTR_W'(n_push);
    rd_ptr_nxt = pop ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + n_push - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem[wr_ptr_r] <= push.res0;
    end
    if (push.push1) begin
      mem[wr_ptr_p1] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign empty        = (count_r == '0);
  assign head         = mem[rd_ptr_r];
  assign status.count = count_r;
  assign status.room2 = (count_r <= Q_CNT_W'(Q_DEPTH - 2));

endmodule

// ----- hdl/http_header_value_extractor_core.sv -----
// ----------------------------------------------------------------------------
// http_header_value_extractor_core
// Finds a configured key at the start of a header line and streams out the
// value bytes, then a length result, or a not-found result at block end.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake          Payload
//  in_      input      in_valid/in_stall  header_byte, last_of_header
//  out_     output     out_valid/out_stall result_kind, value_byte, value_length
//  cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One header byte is taken per cycle while in_stall is low. A byte is held in an
// input register, parsed once the queue has room for two results, and its
// results land in a four-entry result queue; results leave one per cycle while
// out_stall is low, so a byte that ends a value at block end yields two results.
// Input stalls only while the queue holds more than two results.
// Reset is synchronous; it clears the key registers and the parse state.
// Configuration writes are always accepted.
module http_header_value_extractor_core
  import hhve_pkg::*;
#(
  parameter int KEY_MAX_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_header_byte,
  input  logic        in_last_of_header,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [7:0]  out_value_byte,
  output logic [15:0] out_value_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_go;
  logic       q_empty;
  cfg_wr_t    cfg_wr;
  push_t      push;
  result_t    head;
  q_status_t  q_stat;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  // The staged byte is parsed only when the queue can take two results.
  assign s1_go    = s1_valid_r && q_stat.room2;
  assign in_stall = s1_valid_r && !q_stat.room2;

  assign s1_valid_nxt = in_stall ? s1_valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_header_byte;
      s1_last_r <= in_last_of_header;
    end
  end

  hhve_parser #(
    .KEY_MAX_BYTES(KEY_MAX_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_wr),
    .step     (s1_go),
    .hdr_byte (s1_byte_r),
    .hdr_last (s1_last_r),
    .push     (push)
  );

  hhve_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .pop    (out_valid && !out_stall),
    .empty  (q_empty),
    .head   (head),
    .status (q_stat)
  );

  assign out_valid        = !q_empty;
  assign out_result_kind  = head.kind;
  assign out_value_byte   = head.vbyte;
  assign out_value_length = head.vlen;

`ifndef NO_ASSERTIONS
  a_q_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= Q_CNT_W'(Q_DEPTH))
    else $error("result queue count above its depth");

  a_step_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.push0 |-> q_stat.room2)
    else $error("result pushed without room in the queue");

  a_end_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind != RK_BYTE) |-> (out_value_byte == 8'h00))
    else $error("end result carries a value byte");

  a_byte_no_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == RK_BYTE) |-> (out_value_length == 16'd0))
    else $error("value byte result carries a length");
`endif

endmodule
